// ----- hw/rtl/fri_pkg.sv -----
// Shared types and constants for the frequency response table interpolation unit.
package fri_pkg;

    typedef enum logic { CMD_WRITE = 1'b0, CMD_QUERY = 1'b1 } cmd_t;

    localparam logic       STATUS_OK    = 1'b0;
    localparam logic       STATUS_RANGE = 1'b1;
    localparam logic [0:0] REG_POINT_COUNT = 1'b0;
    localparam logic [6:0] POINT_COUNT_RESET = 7'd1;

    // 2*pi in Q16.16
    localparam logic [18:0] TWO_PI_Q16 = 19'd411775;

    // Queued transaction: omega holds entry_omega for writes, converted target for queries.
    typedef struct packed {
        cmd_t        cmd;
        logic [5:0]  index;
        logic [31:0] omega;
        logic [31:0] re;
        logic [31:0] im;
    } q_item_t;

    typedef struct packed {
        logic [31:0] w;
        logic [31:0] re;
        logic [31:0] im;
    } point_t;

endpackage

// ----- hw/rtl/fri_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fri_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hw/rtl/fri_front.sv -----
// Front end: accepts transactions, converts query frequency to rad/s, two-entry queue.
module fri_front import fri_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [5:0]  entry_index,
    input  logic [31:0] entry_omega,
    input  logic [31:0] entry_real,
    input  logic [31:0] entry_imag,
    input  logic [27:0] target_freq,
    output logic        q_valid,
    output q_item_t     q_item,
    input  logic        q_pop
);
    q_item_t    slot_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg;
    logic [47:0] conv;
    logic        push;
    q_item_t     item_in;

    // round half up, then drop the Q16 fraction of the constant
    assign conv = 48'(target_freq) * 48'(TWO_PI_Q16) + 48'd32768;

    always_comb
    begin
        item_in.cmd   = cmd_t'(command);
        item_in.index = entry_index;
        item_in.omega = (cmd_t'(command) == CMD_QUERY) ? conv[47:16] : entry_omega;
        item_in.re    = entry_real;
        item_in.im    = entry_imag;
    end

    assign busy    = (count_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (q_pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(q_pop);
        end
    end
endmodule

// ----- hw/rtl/fri_back.sv -----
// Back end: table writes, range check, linear search, fraction divide and interpolation.
module fri_back import fri_pkg::*; #(
    parameter int MAX_POINTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [6:0]  point_count,
    input  logic        q_valid,
    input  q_item_t     q_item,
    output logic        q_pop,
    output logic        done,
    output logic        status,
    output logic [31:0] resp_real,
    output logic [31:0] resp_imag,
    output logic        exact_hit
);
    localparam int AW = $clog2(MAX_POINTS);

    typedef enum logic [2:0] { S_IDLE, S_FIRST, S_LAST, S_SCAN, S_DIV, S_MUL, S_ADD } state_t;

    state_t        state_reg;
    logic [31:0]   omega_reg, first_w_reg;
    logic [AW-1:0] idx_reg, last_idx, rd_addr;
    point_t        prev_reg, hi_reg, rdata;
    logic [31:0]   rem_reg;
    logic [31:0]   den_reg;
    logic [15:0]   quo_reg;
    logic [3:0]    cnt_reg;
    logic          im_sel_reg;
    logic signed [49:0] prod_reg;
    logic [31:0]   re_res_reg;
    logic          done_reg, status_reg, hit_reg;
    logic [31:0]   out_re_reg, out_im_reg;

    logic          we;
    logic [31:0]   n_eff;
    logic [32:0]   rem2;
    logic signed [32:0] diff;
    logic signed [33:0] sum;
    logic [31:0]   sat;

    always_comb
    begin
        if (point_count == 7'd0)
        begin
            n_eff = 32'd1;
        end
        else if (32'(point_count) > MAX_POINTS)
        begin
            n_eff = MAX_POINTS;
        end
        else
        begin
            n_eff = 32'(point_count);
        end
    end
    assign last_idx = AW'(n_eff - 32'd1);

    assign q_pop = (state_reg == S_IDLE) && q_valid;
    assign we    = q_pop && (q_item.cmd == CMD_WRITE) && (32'(q_item.index) < MAX_POINTS);

    always_comb
    begin
        unique case (state_reg)
            S_FIRST: rd_addr = last_idx;
            S_SCAN:  rd_addr = idx_reg + AW'(1);
            default: rd_addr = '0;
        endcase
    end

    fri_ram #(.WIDTH($bits(point_t)), .DEPTH(MAX_POINTS)) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (AW'(q_item.index)),
        .wdata ({q_item.omega, q_item.re, q_item.im}),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    assign rem2 = {rem_reg, 1'b0};

    always_comb
    begin
        if (im_sel_reg)
        begin
            diff = 33'(signed'(hi_reg.im)) - 33'(signed'(prev_reg.im));
            sum  = 34'(signed'(prev_reg.im)) + 34'(prod_reg >>> 16);
        end
        else
        begin
            diff = 33'(signed'(hi_reg.re)) - 33'(signed'(prev_reg.re));
            sum  = 34'(signed'(prev_reg.re)) + 34'(prod_reg >>> 16);
        end
        if (sum > 34'sd2147483647)
        begin
            sat = 32'h7FFF_FFFF;
        end
        else if (sum < -34'sd2147483648)
        begin
            sat = 32'h8000_0000;
        end
        else
        begin
            sat = sum[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                omega_reg <= q_item.omega;
            end
            S_FIRST:
            begin
                first_w_reg <= rdata.w;
            end
            S_SCAN:
            begin
                hi_reg   <= rdata;
                rem_reg  <= omega_reg - prev_reg.w;
                den_reg  <= rdata.w - prev_reg.w;
                quo_reg  <= '0;
                cnt_reg  <= '0;
                if (idx_reg != last_idx && rdata.w < omega_reg)
                begin
                    prev_reg <= rdata;
                end
            end
            S_DIV:
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (rem2 >= {1'b0, den_reg})
                begin
                    rem_reg <= 32'(rem2 - {1'b0, den_reg});
                    quo_reg <= {quo_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem2[31:0];
                    quo_reg <= {quo_reg[14:0], 1'b0};
                end
            end
            S_MUL:
            begin
                prod_reg <= 50'(signed'({1'b0, quo_reg})) * 50'(diff);
            end
            S_ADD:
            begin
                re_res_reg <= sat;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            im_sel_reg <= 1'b0;
            done_reg   <= 1'b0;
            status_reg <= STATUS_OK;
            hit_reg    <= 1'b0;
            out_re_reg <= '0;
            out_im_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid && q_item.cmd == CMD_QUERY)
                    begin
                        state_reg <= S_FIRST;
                    end
                end
                S_FIRST:
                begin
                    state_reg <= S_LAST;
                end
                S_LAST:
                begin
                    idx_reg <= '0;
                    if (omega_reg < first_w_reg || omega_reg > rdata.w)
                    begin
                        done_reg   <= 1'b1;
                        status_reg <= STATUS_RANGE;
                        hit_reg    <= 1'b0;
                        out_re_reg <= '0;
                        out_im_reg <= '0;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (idx_reg != last_idx && rdata.w < omega_reg)
                    begin
                        idx_reg <= idx_reg + AW'(1);
                    end
                    else if (rdata.w == omega_reg || idx_reg == '0)
                    begin
                        done_reg   <= 1'b1;
                        status_reg <= STATUS_OK;
                        hit_reg    <= 1'b1;
                        out_re_reg <= rdata.re;
                        out_im_reg <= rdata.im;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        im_sel_reg <= 1'b0;
                        state_reg  <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (cnt_reg == 4'd15)
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    if (im_sel_reg)
                    begin
                        done_reg   <= 1'b1;
                        status_reg <= STATUS_OK;
                        hit_reg    <= 1'b0;
                        out_re_reg <= re_res_reg;
                        out_im_reg <= sat;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        im_sel_reg <= 1'b1;
                        state_reg  <= S_MUL;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign resp_real = out_re_reg;
    assign resp_imag = out_im_reg;
    assign exact_hit = hit_reg;
endmodule

// ----- hw/rtl/freq_response_table_interp_unit.sv -----
// Query flow in the back end: an out-of-range target ends once the first and last entries are read,
// a hit ends at its scan position, and interpolation adds a bit-serial divide and a shared multiplier.
// The back end works on one transaction at a time, with the scan over the table RAM port setting its pace;
// a two-entry queue in front takes new transactions while one is being worked on.
// Reset: rst_n clears the queue, the sequencer and sets point_count to 1; table contents
// are undefined until written. Results are never held off by the receiver.
module freq_response_table_interp_unit import fri_pkg::*; #(
    parameter int MAX_POINTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [5:0]  entry_index,
    input  logic [31:0] entry_omega,
    input  logic [31:0] entry_real,
    input  logic [31:0] entry_imag,
    input  logic [27:0] target_freq,
    output logic        done,
    output logic        status,
    output logic [31:0] resp_real,
    output logic [31:0] resp_imag,
    output logic        exact_hit
);
    logic [6:0] point_count_reg;
    logic       q_valid, q_pop;
    q_item_t    q_item;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_POINT_COUNT) ? {25'd0, point_count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= POINT_COUNT_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_POINT_COUNT)
        begin
            point_count_reg <= pwdata[6:0];
        end
    end

    fri_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .entry_index (entry_index),
        .entry_omega (entry_omega),
        .entry_real  (entry_real),
        .entry_imag  (entry_imag),
        .target_freq (target_freq),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    fri_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_count (point_count_reg),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .done        (done),
        .status      (status),
        .resp_real   (resp_real),
        .resp_imag   (resp_imag),
        .exact_hit   (exact_hit)
    );
endmodule

// ----- hw/rtl/fri_checker.sv -----
// Port-level checks for the interpolation unit, bound to the top level.
module fri_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready,
    input logic        done,
    input logic        status,
    input logic [31:0] resp_real,
    input logic [31:0] resp_imag,
    input logic        exact_hit
);
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

    a_range_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        done && status |-> !exact_hit)
        else $error("out of range result flagged as exact hit");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status |-> resp_real == 32'd0 && resp_imag == 32'd0)
        else $error("out of range result carries data");

    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && !paddr[2] ##1 !paddr[2]
        |-> prdata[6:0] == $past(pwdata[6:0]) && prdata[31:7] == 25'd0)
        else $error("point_count readback mismatch");
endmodule

bind freq_response_table_interp_unit fri_checker u_fri_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .done      (done),
    .status    (status),
    .resp_real (resp_real),
    .resp_imag (resp_imag),
    .exact_hit (exact_hit)
);

// ----- tb/freq_response_table_interp_unit_tb.sv -----
// Testbench for the frequency response table interpolation unit.
module freq_response_table_interp_unit_tb;
    import fri_pkg::*;

    typedef struct {
        cmd_t        cmd;
        logic [5:0]  index;
        logic [31:0] omega;
        logic [31:0] re;
        logic [31:0] im;
        logic [27:0] tgt;
    } sweep_txn_t;

    typedef struct {
        logic        status;
        logic [31:0] re;
        logic [31:0] im;
        logic        hit;
    } lookup_t;

    logic        clk, rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic        start, busy, command;
    logic [5:0]  entry_index;
    logic [31:0] entry_omega, entry_real, entry_imag;
    logic [27:0] target_freq;
    logic        done, status, exact_hit;
    logic [31:0] resp_real, resp_imag;

    freq_response_table_interp_unit u_top (.*);

    sweep_txn_t  pend_txns[$];
    lookup_t     expected_lookups[$];
    sweep_txn_t  cur;
    int          idle_pct;
    int          errors, n_queries, n_hits, n_outs, n_interp;

    // predictor state
    logic [31:0] tbl_w[64], tbl_re[64], tbl_im[64];
    logic [6:0]  cfg_count;

    // generation side: targets the current sweep was built from
    logic [27:0] gen_tgt[64];
    int          gen_n;

    always
    begin
        clk = 1'b1; #10;
        clk = 1'b0; #10;
    end

    function automatic logic [31:0] hz_to_omega(logic [27:0] t);
        logic [63:0] p;
        p = 64'(t) * 64'd411775 + 64'd32768;
        return p[47:16];
    endfunction

    function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, logic [31:0] f);
        longint h0, h1, p, r;
        h0 = longint'(signed'(a));
        h1 = longint'(signed'(b));
        p = longint'(f) * (h1 - h0);
        r = h0 + (p >>> 16);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    task automatic apply_txn(sweep_txn_t t);
        int          n, k;
        logic [31:0] om;
        logic [63:0] fr;
        lookup_t     e;
        if (t.cmd == CMD_WRITE) begin
            tbl_w[t.index] = t.omega;
            tbl_re[t.index] = t.re;
            tbl_im[t.index] = t.im;
            return;
        end
        n = (cfg_count == 0) ? 1 : (cfg_count > 64) ? 64 : cfg_count;
        om = hz_to_omega(t.tgt);
        n_queries++;
        e = '{STATUS_OK, 32'd0, 32'd0, 1'b0};
        if (om < tbl_w[0] || om > tbl_w[n-1]) begin
            e.status = STATUS_RANGE;
            n_outs++;
        end else begin
            k = 0;
            while (k < n - 1 && tbl_w[k] < om) k++;
            if (tbl_w[k] == om || k == 0) begin
                e.re = tbl_re[k];
                e.im = tbl_im[k];
                e.hit = 1'b1;
                n_hits++;
            end else begin
                fr = (64'(om - tbl_w[k-1]) << 16) / 64'(tbl_w[k] - tbl_w[k-1]);
                if (fr > 64'hFFFF) fr = 64'hFFFF;
                e.re = blend(tbl_re[k-1], tbl_re[k], fr[31:0]);
                e.im = blend(tbl_im[k-1], tbl_im[k], fr[31:0]);
                n_interp++;
            end
        end
        expected_lookups.push_back(e);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start <= 1'b0;
            command <= CMD_WRITE;
            entry_index <= '0;
            entry_omega <= '0;
            entry_real <= '0;
            entry_imag <= '0;
            target_freq <= '0;
        end else begin
            if (start && !busy)
                apply_txn(cur);
            if (!start || !busy) begin
                if (pend_txns.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    cur = pend_txns.pop_front();
                    start <= 1'b1;
                    command <= cur.cmd;
                    entry_index <= cur.index;
                    entry_omega <= cur.omega;
                    entry_real <= cur.re;
                    entry_imag <= cur.im;
                    target_freq <= cur.tgt;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        lookup_t e;
        if (rst_n && done) begin
            if (expected_lookups.size() == 0) begin
                $display("%0t: unexpected result status=%0b re=%h im=%h hit=%0b",
                         $time, status, resp_real, resp_imag, exact_hit);
                errors++;
            end else begin
                e = expected_lookups.pop_front();
                if (status !== e.status) begin
                    $display("%0t: status exp %0b got %0b", $time, e.status, status);
                    errors++;
                end
                if (resp_real !== e.re) begin
                    $display("%0t: resp_real exp %h got %h", $time, e.re, resp_real);
                    errors++;
                end
                if (resp_imag !== e.im) begin
                    $display("%0t: resp_imag exp %h got %h", $time, e.im, resp_imag);
                    errors++;
                end
                if (exact_hit !== e.hit) begin
                    $display("%0t: exact_hit exp %0b got %0b", $time, e.hit, exact_hit);
                    errors++;
                end
            end
        end
    end

    task automatic push_write(int idx, logic [31:0] om, logic [31:0] re, logic [31:0] im);
        sweep_txn_t t;
        t = '{CMD_WRITE, 6'(idx), om, re, im, 28'($urandom)};
        pend_txns.push_back(t);
    endtask

    task automatic push_query(logic [27:0] tgt);
        sweep_txn_t t;
        t = '{CMD_QUERY, 6'($urandom), $urandom, $urandom, $urandom, tgt};
        pend_txns.push_back(t);
    endtask

    // checked mid-cycle so the driver's updates at the edge have settled
    task automatic wait_drained(int extra);
        while (pend_txns.size() > 0 || start || expected_lookups.size() > 0)
            @(negedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_count(logic [31:0] v);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        cfg_count = v[6:0];
    endtask

    function automatic logic [31:0] rand_resp();
        case ($urandom_range(4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // fill entries 0..n-1 with an ascending sweep
    task automatic load_sweep(int n);
        logic [27:0] t;
        int span;
        span = ($urandom_range(1)) ? $urandom_range(1, 16) : $urandom_range(1, 4000000);
        t = 28'($urandom_range(0, 28'hFFFFFFF - (n + 1) * span));
        for (int i = 0; i < n; i++) begin
            t = t + 28'($urandom_range(1, span));
            gen_tgt[i] = t;
            push_write(i, hz_to_omega(t), rand_resp(), rand_resp());
        end
    endtask

    task automatic random_mix(int count, bit pressure);
        int i, k, a, b;
        for (i = 0; i < count; i++) begin
            if (pressure && i == count / 2)
                wait_drained(0);
            k = $urandom_range(99);
            if (k < 60) begin
                // well-formed lookups: exact points or between neighbors
                a = $urandom_range(gen_n - 1);
                if (k < 20 || gen_n < 2) begin
                    push_query(gen_tgt[a]);
                end else begin
                    b = (a == gen_n - 1) ? a - 1 : a + 1;
                    if (gen_tgt[a] < gen_tgt[b])
                        push_query(28'($urandom_range(gen_tgt[a], gen_tgt[b])));
                    else
                        push_query(28'($urandom_range(gen_tgt[b], gen_tgt[a])));
                end
            end else if (k < 72) begin
                push_query(28'($urandom));
            end else if (k < 80 && gen_n <= 16) begin
                // full reloads only for short sweeps
                load_sweep(gen_n);
            end else if (k < 92) begin
                // new response at same frequency
                a = $urandom_range(gen_n - 1);
                push_write(a, hz_to_omega(gen_tgt[a]), rand_resp(), rand_resp());
            end else begin
                // noise: arbitrary frequency, possibly breaking the ordering
                a = $urandom_range(63);
                push_write(a, $urandom, $urandom, $urandom);
                if (a < 64) gen_tgt[a] = 28'($urandom);
            end
        end
    endtask

    initial
    begin
        int          counts[6];
        int          idles[6];
        logic [31:0] om0;
        errors = 0; n_queries = 0; n_hits = 0; n_outs = 0; n_interp = 0;
        idle_pct = 0;
        cfg_count = POINT_COUNT_RESET;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single point at reset count
        gen_n = 1;
        gen_tgt[0] = 28'd1000;
        om0 = hz_to_omega(28'd1000);
        push_write(0, om0, 32'h7FFF_FFFF, 32'h8000_0000);
        push_query(28'd1000);
        push_query(28'd999);
        push_query(28'd1001);
        push_query(28'd0);
        push_query(28'hFFFFFFF);
        push_write(63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        push_write(62, 32'h0, 32'h0, 32'hFFFF_FFFF);
        wait_drained(120);

        // directed: four points with extreme responses
        write_count(32'd4);
        gen_n = 4;
        for (int i = 0; i < 4; i++) begin
            gen_tgt[i] = 28'(2000 + 1000 * i);
            push_write(i, hz_to_omega(gen_tgt[i]),
                       (i[0]) ? 32'h7FFF_FFFF : 32'h8000_0000,
                       (i[0]) ? 32'h8000_0000 : 32'h7FFF_FFFF);
        end
        push_query(28'd2000);
        push_query(28'd2001);
        push_query(28'd2500);
        push_query(28'd2999);
        push_query(28'd3000);
        push_query(28'd4700);
        push_query(28'd5000);
        push_query(28'd5001);
        push_query(28'd1999);
        wait_drained(120);

        counts = '{64, 1, 2, 0, 127, 13};
        idles  = '{0, 72, 32, 0, 72, 32};
        foreach (counts[p]) begin
            write_count(32'(counts[p]));
            idle_pct = idles[p];
            gen_n = (counts[p] == 0) ? 1 : (counts[p] > 64) ? 64 : counts[p];
            load_sweep(gen_n);
            random_mix((gen_n > 32) ? 25 : 45, p == 2);
            wait_drained(120);
        end

        $display("covered %0d lookups: %0d exact, %0d interpolated, %0d out of range",
                 n_queries, n_hits, n_interp, n_outs);
        $display("point counts 0 to 127 incl. clamped values, idle 0/32/72 percent");
        if (errors == 0)
            $display("freq_response_table_interp_unit_tb: PASS");
        else
            $display("freq_response_table_interp_unit_tb: FAIL");
        $finish;
    end

    initial
    begin
        #(20 * 1000000);
        $display("freq_response_table_interp_unit_tb: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/fri_pkg.sv
hw/rtl/fri_ram.sv
hw/rtl/fri_front.sv
hw/rtl/fri_back.sv
hw/rtl/freq_response_table_interp_unit.sv
hw/rtl/fri_checker.sv
tb/freq_response_table_interp_unit_tb.sv
